[design/assert_macros.svh]
// Assertion macros shared by the directory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_SYNC(label, clk, rst_n, !(expr), msg)

`endif

[design/msi_dir_pkg.sv]
// Types and constants shared by the MSI directory modules.
`timescale 1ns / 1ps

package msi_dir_pkg;

    localparam int NUM_LINES_DEF = 4096;
    localparam int NUM_PROCS_DEF = 4;

    localparam int LINE_MAX_W  = 16;
    localparam int ADDR_W      = 18;
    localparam int REQ_W       = 2;
    localparam int MASK_W      = 4;
    localparam int LAT_W       = 40;
    localparam int ADD_W       = 8;
    localparam int LSL_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    localparam logic [LSL_W-1:0] LSL_RESET = 3'd2;

    localparam logic [ADD_W-1:0] LAT_HIT        = 8'd2;
    localparam logic [ADD_W-1:0] LAT_REMOTE     = 8'd22;
    localparam logic [ADD_W-1:0] LAT_MEM        = 8'd222;
    localparam logic [ADD_W-1:0] LAT_WR_MISS    = 8'd220;
    localparam logic [ADD_W-1:0] LAT_WR_OWN     = 8'd200;
    localparam logic [ADD_W-1:0] LAT_WR_FILL    = LAT_HIT + LAT_WR_MISS;
    localparam logic [ADD_W-1:0] LAT_WR_OWNED   = LAT_HIT + LAT_WR_OWN;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        LS_INVALID  = 2'd0,
        LS_SHARED   = 2'd1,
        LS_MODIFIED = 2'd2
    } t_line_state;

    typedef enum logic [1:0] {
        BE_CLEAR,
        BE_IDLE,
        BE_EXEC
    } t_be_state;

    typedef struct packed {
        logic [REQ_W-1:0]  owner;
        logic [MASK_W-1:0] sharers;
        t_line_state       state;
    } t_dir_entry;

    localparam int DIR_W = $bits(t_dir_entry);

    typedef struct packed {
        t_op                   op;
        logic [REQ_W-1:0]      who;
        logic [LINE_MAX_W-1:0] line;
    } t_req;

    typedef struct packed {
        t_line_state       line_state;
        logic [MASK_W-1:0] downgrade;
        logic [MASK_W-1:0] invalidate;
        logic [LAT_W-1:0]  total;
        logic [ADD_W-1:0]  latency;
        logic [REQ_W-1:0]  requester;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_be_status;

endpackage

[design/msi_dir_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module msi_dir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/msi_dir_front.sv]
// Front end: line size register, request intake and classification.
`timescale 1ns / 1ps

module msi_dir_front
    import msi_dir_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LSL_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [REQ_W-1:0]  i_requester,
    input  logic [ADDR_W-1:0] i_address,
    input  t_q_status         i_q_status,
    input  t_be_status        i_be_status,
    output logic              o_push,
    output t_req              o_req
);

    localparam int LINE_W = $clog2(NUM_LINES);

    logic [LSL_W-1:0]  r_lsl;
    logic [REQ_W:0]    w_req_ext;
    logic [ADDR_W-1:0] w_shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsl <= LSL_RESET;
        end else if (i_cfg_we) begin
            r_lsl <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_req_ext = {1'b0, i_requester};
        w_shifted = i_address >> r_lsl;
        o_req      = '0;
        o_req.op   = t_op'(i_op);
        o_req.who  = i_requester;
        if (w_req_ext >= (REQ_W+1)'(NUM_PROCS)) begin
            o_req.who = REQ_W'(w_req_ext - (REQ_W+1)'(NUM_PROCS));
        end
        o_req.line[LINE_W-1:0] = w_shifted[LINE_W-1:0];
    end

    assign o_ready = !i_q_status.full && !i_be_status.clearing;
    assign o_push  = i_valid && o_ready;

endmodule

[design/msi_dir_queue.sv]
// Short request queue between front end and back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msi_dir_queue
    import msi_dir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_req      i_req,
    input  logic      i_pop,
    output t_req      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_req             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, o_status.full && i_push, "queue overflow")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, o_status.empty && i_pop, "queue underflow")
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

[design/msi_dir_back.sv]
// Back end: directory read-modify-write, latency accounting, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msi_dir_back
    import msi_dir_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_req       i_q_head,
    output logic       o_pop,
    output t_be_status o_status,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    output t_result    o_m_result
);

    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int PROC_W = (NUM_PROCS > 2) ? 2 : 1;

    t_be_state         r_state, n_state;
    logic [LINE_W-1:0] r_clr, n_clr;
    t_req              r_req, n_req;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic [LAT_W-1:0]  r_lat [NUM_PROCS];

    logic              w_we;
    logic [LINE_W-1:0] w_waddr;
    t_dir_entry        w_wdata;
    logic              w_re;
    logic [LINE_W-1:0] w_raddr;
    logic [DIR_W-1:0]  w_rdata;

    t_dir_entry        w_old, w_new;
    logic [MASK_W-1:0] w_bit, w_own_bit, w_inval, w_down;
    logic [ADD_W-1:0]  w_lat;
    logic [PROC_W-1:0] w_idx;
    logic [LAT_W-1:0]  w_tot_old, w_tot_new;
    logic [LAT_W:0]    w_sum;
    logic              w_fire;

    msi_dir_ram #(
        .WIDTH (DIR_W),
        .DEPTH (NUM_LINES)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_old     = t_dir_entry'(w_rdata);
        w_new     = w_old;
        w_bit     = MASK_W'(1) << r_req.who;
        w_own_bit = MASK_W'(1) << w_old.owner;
        w_inval   = '0;
        w_down    = '0;
        w_lat     = '0;
        if (r_req.op == OP_READ) begin
            case (w_old.state)
                LS_MODIFIED: begin
                    w_lat  = (w_old.owner == r_req.who) ? LAT_HIT : LAT_REMOTE;
                    w_down = w_own_bit;
                end
                LS_SHARED: begin
                    w_lat = (|(w_old.sharers & w_bit)) ? LAT_HIT : LAT_REMOTE;
                end
                default: begin
                    w_lat = LAT_MEM;
                end
            endcase
            w_new.state   = LS_SHARED;
            w_new.sharers = w_old.sharers | w_down | w_bit;
        end else begin
            case (w_old.state)
                LS_MODIFIED: begin
                    if (w_old.owner == r_req.who) begin
                        w_lat = LAT_WR_OWNED;
                    end else begin
                        w_lat   = LAT_WR_FILL;
                        w_inval = w_own_bit;
                    end
                end
                LS_SHARED: begin
                    w_lat   = LAT_WR_FILL;
                    w_inval = w_old.sharers & ~w_bit;
                end
                default: begin
                    w_lat = LAT_WR_FILL;
                end
            endcase
            w_new.state   = LS_MODIFIED;
            w_new.owner   = r_req.who;
            w_new.sharers = '0;
        end

        w_idx     = r_req.who[PROC_W-1:0];
        w_tot_old = r_lat[w_idx];
        w_sum     = {1'b0, w_tot_old} + (LAT_W+1)'(w_lat);
        w_tot_new = w_sum[LAT_W] ? '1 : w_sum[LAT_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_req       = r_req;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_re        = 1'b0;
        w_raddr     = i_q_head.line[LINE_W-1:0];
        w_we        = 1'b0;
        w_waddr     = r_req.line[LINE_W-1:0];
        w_wdata     = w_new;
        w_fire      = 1'b0;
        case (r_state)
            BE_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = t_dir_entry'('0);
                n_clr   = r_clr + 1'b1;
                if (r_clr == LINE_W'(NUM_LINES - 1)) begin
                    n_state = BE_IDLE;
                end
            end
            BE_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    w_re    = 1'b1;
                    n_req   = i_q_head;
                    n_state = BE_EXEC;
                end
            end
            BE_EXEC: begin
                if (!r_out_valid || i_m_ready) begin
                    w_fire           = 1'b1;
                    w_we             = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out.line_state = w_new.state;
                    n_out.downgrade  = w_down;
                    n_out.invalidate = w_inval;
                    n_out.total      = w_tot_new;
                    n_out.latency    = w_lat;
                    n_out.requester  = r_req.who;
                    n_state          = BE_IDLE;
                end
            end
            default: begin
                n_state = BE_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BE_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PROCS; p++) begin
                r_lat[p] <= '0;
            end
        end else if (w_fire) begin
            r_lat[w_idx] <= w_tot_new;
        end
    end

    assign o_status.clearing = (r_state == BE_CLEAR);
    assign o_m_valid         = r_out_valid;
    assign o_m_result        = r_out;

    `ASSERT_SYNC(a_result_from_exec, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == BE_EXEC), "result loaded outside update step")
    `ASSERT_SYNC(a_pop_then_exec, i_clk, i_rst_n, o_pop |=> (r_state == BE_EXEC), "popped request not executed")
    `ASSERT_SYNC(a_total_grows, i_clk, i_rst_n, w_fire |=> (r_out.total >= $past(w_tot_old)), "running latency decreased")

endmodule

[design/msi_directory_coherence.sv]
// Top level of the four-processor MSI coherence directory.
//
//  channel  | direction | handshake                     | contents
//  ---------+-----------+-------------------------------+-----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | one processor read or write
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | one directory result per request
//  cfg      | in        | i_cfg_we (no wait)            | line_size_log2
//
//  Each transaction takes two steps in the back end: one directory RAM read, one update step
//  that writes the entry back and loads the result register once m_axis has taken the last result.
//  After reset the directory RAM is swept to invalid, one line per cycle, over all NUM_LINES lines
//  (4096 by default); s_axis_tready stays low until the sweep ends.
//  A two-entry queue sits between intake and back end; intake keeps taking transactions while
//  m_axis stalls until the queue fills.
`timescale 1ns / 1ps

module msi_directory_coherence
    import msi_dir_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [LSL_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] requester, [19:2] address, [23:20] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] requester_echo, [9:2] latency_added, [49:10] total_latency,
    // [53:50] invalidate_mask, [57:54] downgrade_mask, [59:58] line_state_after, [63:60] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       w_push;
    t_req       w_req;
    logic       w_pop;
    t_req       w_head;
    t_q_status  w_q_status;
    t_be_status w_be_status;
    t_result    w_result;

    msi_dir_front #(
        .NUM_LINES (NUM_LINES),
        .NUM_PROCS (NUM_PROCS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_requester (s_axis_tdata[REQ_W-1:0]),
        .i_address   (s_axis_tdata[REQ_W+ADDR_W-1:REQ_W]),
        .i_q_status  (w_q_status),
        .i_be_status (w_be_status),
        .o_push      (w_push),
        .o_req       (w_req)
    );

    msi_dir_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_req    (w_req),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    msi_dir_back #(
        .NUM_LINES (NUM_LINES),
        .NUM_PROCS (NUM_PROCS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_q_head   (w_head),
        .o_pop      (w_pop),
        .o_status   (w_be_status),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_result (w_result)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), w_result};

endmodule

[sim/tb.sv]
// Self-checking testbench for the four-processor MSI coherence directory.
`timescale 1ns / 1ps

module tb;
    import msi_dir_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 89;
    localparam int POOL_SIZE    = 12;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_TRIGGER = 150;

    typedef struct packed {
        t_op              op;
        logic [REQ_W-1:0] who;
        logic [ADDR_W-1:0] addr;
    } t_access;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [LSL_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_access           access_q[$];
    t_result           outcome_q[$];
    t_line_state       dir_state [NUM_LINES_DEF];
    logic [MASK_W-1:0] dir_sharers [NUM_LINES_DEF];
    logic [REQ_W-1:0]  dir_owner [NUM_LINES_DEF];
    logic [LAT_W-1:0]  proc_total [NUM_PROCS_DEF];
    logic [LSL_W-1:0]  line_lsl = LSL_RESET;

    int   cycles = 0;
    int   mismatches = 0;
    int   results_seen = 0;
    bit   offering = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   rx_cyc = 0;
    int   rx_mode = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    msi_directory_coherence u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic clear_directory();
        for (int i = 0; i < NUM_LINES_DEF; i++) begin
            dir_state[i]   = LS_INVALID;
            dir_sharers[i] = '0;
            dir_owner[i]   = '0;
        end
        for (int p = 0; p < NUM_PROCS_DEF; p++) begin
            proc_total[p] = '0;
        end
        line_lsl = LSL_RESET;
    endtask

    function automatic t_result apply_access(t_access acc);
        logic [ADDR_W-1:0] shifted;
        int                line;
        logic [MASK_W-1:0] req_bit;
        logic [MASK_W-1:0] shr;
        logic [MASK_W-1:0] inval;
        logic [MASK_W-1:0] down;
        logic [REQ_W-1:0]  own;
        t_line_state       st;
        logic [ADD_W-1:0]  lat;
        logic [LAT_W:0]    sum;
        t_result           res;
        shifted = acc.addr >> line_lsl;
        line    = int'(shifted) % NUM_LINES_DEF;
        req_bit = MASK_W'(1) << acc.who;
        st      = dir_state[line];
        own     = dir_owner[line];
        shr     = dir_sharers[line];
        inval   = '0;
        down    = '0;
        if (acc.op == OP_READ) begin
            case (st)
                LS_MODIFIED: begin
                    lat  = (own == acc.who) ? LAT_HIT : LAT_REMOTE;
                    down = MASK_W'(1) << own;
                    shr  = shr | down;
                end
                LS_SHARED: begin
                    lat = ((shr & req_bit) != '0) ? LAT_HIT : LAT_REMOTE;
                end
                default: begin
                    lat = LAT_MEM;
                end
            endcase
            dir_state[line]   = LS_SHARED;
            dir_sharers[line] = shr | req_bit;
        end else begin
            if (st == LS_MODIFIED && own == acc.who) begin
                lat = LAT_WR_OWNED;
            end else begin
                lat = LAT_WR_FILL;
                if (st == LS_MODIFIED) begin
                    inval = MASK_W'(1) << own;
                end else if (st == LS_SHARED) begin
                    inval = shr & ~req_bit;
                end
            end
            dir_state[line]   = LS_MODIFIED;
            dir_owner[line]   = acc.who;
            dir_sharers[line] = '0;
        end
        sum = {1'b0, proc_total[acc.who]} + lat;
        proc_total[acc.who] = sum[LAT_W] ? '1 : sum[LAT_W-1:0];
        res.requester  = acc.who;
        res.latency    = lat;
        res.total      = proc_total[acc.who];
        res.invalidate = inval;
        res.downgrade  = down;
        res.line_state = dir_state[line];
        return res;
    endfunction

    task automatic check_field(string name, logic [LAT_W-1:0] want, logic [LAT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got = m_axis_tdata[RESULT_W-1:0];
        results_seen++;
        if (outcome_q.size() == 0) begin
            $error("requester_echo: expected none, actual %0d", got.requester);
            mismatches++;
        end else begin
            want = outcome_q.pop_front();
            check_field("requester_echo", want.requester, got.requester);
            check_field("latency_added", want.latency, got.latency);
            check_field("total_latency", want.total, got.total);
            check_field("invalidate_mask", want.invalidate, got.invalidate);
            check_field("downgrade_mask", want.downgrade, got.downgrade);
            check_field("line_state_after", want.line_state, got.line_state);
        end
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (!i_rst_n) begin
            clear_directory();
        end else begin
            if (i_cfg_we) begin
                line_lsl = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                outcome_q = {outcome_q, apply_access(access_q.pop_front())};
                offering = 1'b0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
        end
    end

    always @(negedge i_clk) begin
        if (!offering) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (access_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'd0, access_q[0].addr, access_q[0].who};
                s_axis_tuser  <= access_q[0].op;
                offering = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        bit ready;
        rx_cyc++;
        if (hold_left > 0) begin
            hold_left--;
        end
        if (!hold_done && results_seen >= HOLD_TRIGGER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (rx_cyc % 97 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: ready = 1'b1;
            1: ready = $urandom_range(0, 1);
            2: ready = ($urandom_range(0, 4) == 0);
            default: ready = ((rx_cyc % 16) < 12);
        endcase
        m_axis_tready <= (hold_left == 0) && ready;
    end

    task automatic queue_access(t_op op, int who, int addr);
        t_access acc;
        acc.op   = op;
        acc.who  = REQ_W'(who);
        acc.addr = ADDR_W'(addr);
        access_q = {access_q, acc};
    endtask

    task automatic queue_random(int lsl, int count);
        logic [ADDR_W-1:0] pool [POOL_SIZE];
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        int                pick;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool[i] = ADDR_W'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            base = pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 70) begin
                addr = base ^ ADDR_W'($urandom_range(0, (1 << lsl) - 1));
            end else if (pick < 85) begin
                addr = base + ADDR_W'((NUM_LINES_DEF << lsl) * $urandom_range(1, 3));
            end else begin
                addr = ADDR_W'($urandom);
            end
            queue_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                         $urandom_range(0, NUM_PROCS_DEF - 1), addr);
        end
    endtask

    task automatic wait_idle();
        while (access_q.size() != 0 || outcome_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_line_size(int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LSL_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int lsl_plan [6];
        lsl_plan = '{0, 7, 6, 3, 1, 5};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_access(OP_READ,  0, 0);
        queue_access(OP_READ,  0, 1);
        queue_access(OP_READ,  1, 2);
        queue_access(OP_WRITE, 0, 3);
        queue_access(OP_WRITE, 0, 0);
        queue_access(OP_READ,  0, 0);
        queue_access(OP_WRITE, 2, 0);
        queue_access(OP_READ,  3, 0);
        queue_access(OP_WRITE, 3, 0);
        queue_access(OP_WRITE, 1, 0);
        queue_access(OP_WRITE, 2, 262143);
        queue_access(OP_READ,  3, 262143);
        queue_access(OP_READ,  2, 16384);
        queue_access(OP_WRITE, 3, 16385);
        queue_access(OP_READ,  0, 'h2AAAA);
        queue_access(OP_READ,  1, 'h15555);
        queue_access(OP_WRITE, 3, 'h2AAAA);
        queue_access(OP_READ,  2, 'h15555);
        wait_idle();

        foreach (lsl_plan[p]) begin
            write_line_size(lsl_plan[p]);
            queue_random(lsl_plan[p], PHASE_ITEMS);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/msi_dir_pkg.sv
design/msi_dir_ram.sv
design/msi_dir_front.sv
design/msi_dir_queue.sv
design/msi_dir_back.sv
design/msi_directory_coherence.sv
sim/tb.sv
